>>> design/adcps_pkg.sv
// Shared types, widths and constants for the antialiased disc pixel shader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package adcps_pkg;

    // Field widths
    localparam int CoordW  = 12;               // pixel_x, pixel_y
    localparam int CenterW = 13;               // signed disc centre
    localparam int RadW    = 12;               // disc radius
    localparam int ColorW  = 24;               // packed RGB
    localparam int ChanW   = 8;                // one color channel
    localparam int NumChan = ColorW / ChanW;

    // Coverage precision
    localparam int CovFracBits = 8;
    localparam int One         = 1 << CovFracBits;

    // Offset and distance widths (CoordW < CenterW)
    localparam int DeltaW = CenterW + 1;       // signed pixel minus centre
    localparam int SqW    = 2 * (DeltaW - 1);  // square of one offset
    localparam int D2W    = SqW + 1;           // sum of both squares
    localparam int LimW   = 2 * RadW;          // r*r + r and r*r - r

    // Square root unit widths
    localparam int XW     = LimW + 2 * CovFracBits;
    localparam int XWE    = XW + (XW % 2);     // radicand, even width
    localparam int RootW  = XWE / 2;
    localparam int RemW   = RootW + 2;

    // Coverage arithmetic: k = (2r+1) << (F-1), a = k - ceil(sqrt)
    localparam int KW = RadW + CovFracBits;
    localparam int AW = ((KW > RootW + 1) ? KW : RootW + 1) + 1;

    // Queue between front and back (depth is a power of two)
    localparam int FifoDepth   = 8;
    localparam int FifoAw      = $clog2(FifoDepth);
    localparam int FifoCntW    = FifoAw + 1;
    localparam int FrontStages = 4;
    localparam int InflW       = $clog2(FrontStages + 1);
    localparam int CreditW     = FifoCntW + 1;

    // Configuration port
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = ColorW;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTER_X   = 4'd0,
        REG_CENTER_Y   = 4'd1,
        REG_RADIUS     = 4'd2,
        REG_FILL_COLOR = 4'd3
    } reg_idx_t;

    // Pixel class decided by the front, refined by the back
    typedef enum logic [1:0] {
        CLS_PASS  = 2'd0,   // untouched
        CLS_FILL  = 2'd1,   // full coverage
        CLS_EDGE  = 2'd2,   // on the rim, coverage still to compute
        CLS_BLEND = 2'd3    // partial coverage, blend with alpha
    } cls_t;

    // One classified pixel in the queue
    typedef struct packed {
        cls_t              cls;
        logic [LimW-1:0]   d2;
        logic [ColorW-1:0] dst;
    } adcps_item_t;

    // Queue status seen by the top level and the back
    typedef struct packed {
        logic [FifoCntW-1:0] count;
        logic                not_empty;
    } adcps_fifo_stat_t;

endpackage

`default_nettype wire

>>> design/adcps_front.sv
// Front part: takes pixels, forms squared distance to the disc centre and
// classifies each pixel as outside, inside or on the rim. Uses adcps_pkg.
`default_nettype none

module adcps_front import adcps_pkg::*; (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [CoordW-1:0]          in_x,
    input  wire logic [CoordW-1:0]          in_y,
    input  wire logic [ColorW-1:0]          in_dst,
    input  wire logic signed [CenterW-1:0]  center_x,
    input  wire logic signed [CenterW-1:0]  center_y,
    input  wire logic [RadW-1:0]            radius,
    output logic                            push,
    output adcps_item_t                     push_item,
    output logic [InflW-1:0]                inflight
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DeltaW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SqW-1:0]    sqx_reg, sqy_reg;
    logic signed [2*DeltaW-1:0] prod_x, prod_y;
    logic [D2W-1:0]    d2_reg;
    logic [ColorW-1:0] dst1_reg, dst2_reg, dst3_reg;
    logic [LimW-1:0]   rr_reg, lim_hi_reg, lim_lo_reg;
    adcps_item_t       item_reg, item_next;

    // Offsets from the centre
    assign dx_next = $signed({2'b00, in_x}) - $signed({center_x[CenterW-1], center_x});
    assign dy_next = $signed({2'b00, in_y}) - $signed({center_y[CenterW-1], center_y});

    // Squares, always non-negative
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    // Classify against the rim limits
    always_comb
    begin
        item_next     = '0;
        item_next.dst = dst3_reg;
        item_next.d2  = d2_reg[LimW-1:0];
        if (radius == '0 || d2_reg > D2W'(lim_hi_reg))
        begin
            item_next.cls = CLS_PASS;
        end
        else if (d2_reg <= D2W'(lim_lo_reg))
        begin
            item_next.cls = CLS_FILL;
        end
        else
        begin
            item_next.cls = CLS_EDGE;
        end
    end

    // Stage valid bits; the front never stalls, admission is by credit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Datapath stages and rim limits
    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dst1_reg   <= in_dst;
        sqx_reg    <= prod_x[SqW-1:0];
        sqy_reg    <= prod_y[SqW-1:0];
        dst2_reg   <= dst1_reg;
        d2_reg     <= D2W'(sqx_reg) + D2W'(sqy_reg);
        dst3_reg   <= dst2_reg;
        item_reg   <= item_next;
        rr_reg     <= radius * radius;
        lim_hi_reg <= rr_reg + LimW'(radius);
        lim_lo_reg <= rr_reg - LimW'(radius);
    end

    assign push      = v4_reg;
    assign push_item = item_reg;
    assign inflight  = InflW'(v1_reg) + InflW'(v2_reg) + InflW'(v3_reg) + InflW'(v4_reg);

endmodule

`default_nettype wire

>>> design/adcps_fifo.sv
// Short queue of classified pixels between the front and the back.
// Uses adcps_pkg for the item type and depth.
`default_nettype none

module adcps_fifo import adcps_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire adcps_item_t  push_item,
    input  wire logic         pop,
    output adcps_item_t       head_item,
    output adcps_fifo_stat_t  stat
);

    adcps_item_t         mem [FifoDepth];
    adcps_item_t         head_reg;
    logic [FifoAw-1:0]   wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [FifoCntW-1:0] count_reg, count_next;

    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    // Storage and registered head; the entry being written is forwarded
    // when it becomes the new head
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_item;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign count_next = count_reg + FifoCntW'(push) - FifoCntW'(pop);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item      = head_reg;
    assign stat.count     = count_reg;
    assign stat.not_empty = (count_reg != '0);

endmodule

`default_nettype wire

>>> design/adcps_back.sv
// Back part: pipelined square root for rim pixels, coverage decision,
// channel blend and output register. Uses adcps_pkg.
`default_nettype none

module adcps_back import adcps_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [RadW-1:0]    radius,
    input  wire logic [ColorW-1:0]  fill_color,
    input  wire adcps_fifo_stat_t   fifo_stat,
    input  wire adcps_item_t        head_item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ColorW-1:0]       out_pixel,
    output logic                    out_written
);

    typedef struct packed {
        logic              v;
        cls_t              cls;
        logic [ColorW-1:0] dst;
        logic [XWE-1:0]    x;
        logic [RemW-1:0]   rem;
        logic [RootW-1:0]  root;
    } sq_stage_t;

    typedef struct packed {
        logic                   v;
        cls_t                   cls;
        logic [ColorW-1:0]      dst;
        logic [CovFracBits-1:0] alpha;
    } dec_stage_t;

    // One bit of the root: restoring digit step
    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t       o;
        logic [RemW+1:0] trial_a;
        logic [RemW+1:0] trial_b;
        logic [RemW+1:0] diff;
        o       = s;
        trial_a = {s.rem, s.x[XWE-1 -: 2]};
        trial_b = {{(RemW-RootW){1'b0}}, s.root, 2'b01};
        diff    = trial_a - trial_b;
        o.x     = s.x << 2;
        if (trial_a >= trial_b)
        begin
            o.rem  = diff[RemW-1:0];
            o.root = {s.root[RootW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = trial_a[RemW-1:0];
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    sq_stage_t  sq_reg  [RootW+1];
    sq_stage_t  sq_next [RootW+1];
    dec_stage_t dec_reg, dec_next;
    logic       en;

    logic                  out_valid_reg, out_written_reg;
    logic [ColorW-1:0]     out_pixel_reg;
    logic [ColorW-1:0]     pixel_next;
    logic                  written_next;

    logic [KW-1:0]         k_val;
    logic [RootW:0]        s_ceil;
    logic signed [AW-1:0]  a_val, one_s;

    logic [ChanW-1:0]          fg_ch, dst_ch;
    logic [CovFracBits:0]      inv_a;
    logic [ChanW+CovFracBits-1:0] p_fg;
    logic [ChanW+CovFracBits:0]   p_dst;
    logic [ChanW+CovFracBits+1:0] mix;
    logic [ColorW-1:0]         blend;

    // Whole back pipeline moves when the output slot is free or drained
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && fifo_stat.not_empty;

    // Root stages: load from the queue, then one digit per stage
    always_comb
    begin
        sq_next[0]      = '0;
        sq_next[0].v    = pop;
        sq_next[0].cls  = head_item.cls;
        sq_next[0].dst  = head_item.dst;
        sq_next[0].x    = XWE'(head_item.d2) << (2 * CovFracBits);
        for (int i = 0; i < RootW; i++)
        begin
            sq_next[i+1] = sqrt_step(sq_reg[i]);
        end
    end

    // Coverage: a = k - ceil(sqrt(d2 * 2^2F))
    always_comb
    begin
        k_val  = KW'({radius, 1'b1}) << (CovFracBits - 1);
        s_ceil = {1'b0, sq_reg[RootW].root} + (RootW+1)'(sq_reg[RootW].rem != '0);
        a_val  = $signed(AW'(k_val)) - $signed(AW'(s_ceil));
        one_s  = AW'(One);

        dec_next       = '0;
        dec_next.v     = sq_reg[RootW].v;
        dec_next.dst   = sq_reg[RootW].dst;
        dec_next.cls   = sq_reg[RootW].cls;
        dec_next.alpha = a_val[CovFracBits-1:0];
        if (sq_reg[RootW].cls == CLS_EDGE)
        begin
            if (a_val >= one_s)
            begin
                dec_next.cls = CLS_FILL;
            end
            else if (a_val > 0)
            begin
                dec_next.cls = CLS_BLEND;
            end
            else
            begin
                dec_next.cls = CLS_PASS;
            end
        end
    end

    // Per-channel blend: (fg*a + dst*(One-a)) >> F
    always_comb
    begin
        fg_ch  = '0;
        dst_ch = '0;
        inv_a  = (CovFracBits+1)'(One) - {1'b0, dec_reg.alpha};
        p_fg   = '0;
        p_dst  = '0;
        mix    = '0;
        blend  = '0;
        for (int c = 0; c < NumChan; c++)
        begin
            fg_ch  = fill_color[c*ChanW +: ChanW];
            dst_ch = dec_reg.dst[c*ChanW +: ChanW];
            p_fg   = fg_ch * dec_reg.alpha;
            p_dst  = dst_ch * inv_a;
            mix    = {2'b00, p_fg} + {1'b0, p_dst};
            blend[c*ChanW +: ChanW] = mix[CovFracBits +: ChanW];
        end
    end

    // Result selection
    always_comb
    begin
        case (dec_reg.cls)
            CLS_FILL:
            begin
                pixel_next   = fill_color;
                written_next = 1'b1;
            end
            CLS_BLEND:
            begin
                pixel_next   = blend;
                written_next = 1'b1;
            end
            default:
            begin
                pixel_next   = dec_reg.dst;
                written_next = 1'b0;
            end
        endcase
    end

    // Pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= RootW; i++)
            begin
                sq_reg[i] <= '0;
            end
            dec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i <= RootW; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            dec_reg       <= dec_next;
            out_valid_reg <= dec_reg.v;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pixel_reg   <= pixel_next;
            out_written_reg <= written_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign out_written = out_written_reg;

endmodule

`default_nettype wire

>>> design/antialiased_disc_pixel_shader.sv
// Antialiased filled disc shader, top level. Uses adcps_pkg, adcps_front, adcps_fifo, adcps_back.
// Path from request acceptance to m_tvalid: 4 front stages, queue write, 21 square-root
// stages, coverage, blend/output register. Throughput: one pixel per cycle unless m_tready
// stalls the output; input admission is credit based on the 8-entry queue.
// Reset (rst_n, async, active low) clears the disc registers to 0 and empties queue and pipeline.
`default_nettype none

module antialiased_disc_pixel_shader import adcps_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Pixel requests
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: pixel_x[11:0], pixel_y[23:12], dst_pixel[47:24]
    input  wire logic [47:0]          s_tdata,
    // Shaded pixels
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [ColorW-1:0]         m_tdata,    // pixel_out[23:0]
    output logic                      m_tuser,    // written[0]
    // Configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_data
);

    logic signed [CenterW-1:0] center_x_reg, center_y_reg;
    logic [RadW-1:0]           radius_reg;
    logic [ColorW-1:0]         fill_color_reg;

    logic             accept;
    logic             push, pop;
    adcps_item_t      push_item, head_item;
    adcps_fifo_stat_t fifo_stat;
    logic [InflW-1:0] inflight;
    logic [CreditW-1:0] credit_used;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radius_reg     <= '0;
            fill_color_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_data[CenterW-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[CenterW-1:0];
                REG_RADIUS:     radius_reg     <= cfg_data[RadW-1:0];
                REG_FILL_COLOR: fill_color_reg <= cfg_data[ColorW-1:0];
                default:        ;
            endcase
        end
    end

    // Admit a request only when the queue can hold everything in flight
    assign credit_used = CreditW'(fifo_stat.count) + CreditW'(inflight);
    assign s_tready    = (credit_used < CreditW'(FifoDepth));
    assign accept      = s_tvalid && s_tready;

    adcps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_x       (s_tdata[CoordW-1:0]),
        .in_y       (s_tdata[2*CoordW-1:CoordW]),
        .in_dst     (s_tdata[2*CoordW+ColorW-1:2*CoordW]),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .radius     (radius_reg),
        .push       (push),
        .push_item  (push_item),
        .inflight   (inflight)
    );

    adcps_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .stat       (fifo_stat)
    );

    adcps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .radius      (radius_reg),
        .fill_color  (fill_color_reg),
        .fifo_stat   (fifo_stat),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (m_tdata),
        .out_written (m_tuser)
    );

    // Queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_stat.count < FifoCntW'(FifoDepth)))
        else $error("queue written while full");

    // Credit accounting stays within the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= CreditW'(FifoDepth))
        else $error("items in flight exceed queue space");

    // An accepted request shows up in the front stages
    a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (inflight != '0))
        else $error("accepted request lost in front");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for antialiased_disc_pixel_shader: directed rows, then random discs.
// Depends on adcps_pkg and the shader RTL; needs no other files.
`timescale 1ns / 100ps

module tb_top;
    import adcps_pkg::*;

    localparam int NumRandPhases  = 8;
    localparam int ItemsPerPhase  = 66;
    localparam int HoldPhase      = 3;
    localparam int HoldCycles     = 300;
    localparam int SettleCycles   = 40;
    localparam int WatchdogLimit  = 3000;
    localparam int MaxReports     = 20;
    localparam int MaxCoord       = (1 << CoordW) - 1;
    localparam logic [CfgIdxW-1:0] SpareRegIdx = 4'd9;

    typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

    // One row of the directed table: a register write or a pixel request
    typedef struct packed {
        row_kind_t           kind;
        logic [CfgIdxW-1:0]  idx;
        logic [CoordW-1:0]   px;
        logic [CoordW-1:0]   py;
        logic [ColorW-1:0]   val;       // register data or dst_pixel
        logic                typed;     // expected result given in the row
        logic [ColorW-1:0]   exp_out;
        logic                exp_wr;
    } dir_row_t;

    typedef struct packed {
        logic [ColorW-1:0] pixel_out;
        logic              written;
    } shade_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;    // pixel_x[11:0], pixel_y[23:12], dst_pixel[47:24]
    logic                m_tvalid;
    logic                m_tready;
    logic [ColorW-1:0]   m_tdata;    // pixel_out[23:0]
    logic                m_tuser;    // written[0]
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // Shadow of the disc registers
    logic signed [CenterW-1:0] cx_sh;
    logic signed [CenterW-1:0] cy_sh;
    logic [RadW-1:0]           rad_sh;
    logic [ColorW-1:0]         fill_sh;

    shade_t   shaded_q[$];
    dir_row_t dir_rows[$];
    shade_t   want;
    logic     hold_req = 1'b0;
    int       err_cnt = 0;
    int       n_pixels = 0;
    int       n_written = 0;
    int       n_partial = 0;
    int       n_writes = 0;
    int       idle_cycles = 0;

    antialiased_disc_pixel_shader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // floor(sqrt(v)), built one root bit at a time from the top
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Expected shading of one pixel against the current disc
    function automatic shade_t shade_pixel(input logic [CoordW-1:0] px,
                                           input logic [CoordW-1:0] py,
                                           input logic [ColorW-1:0] dst,
                                           output bit partial);
        shade_t          res;
        longint          dx, dy, d2, r, rad_sq, k, alpha;
        longint unsigned scaled, root;
        longint          fg, bg;
        res.pixel_out = dst;
        res.written   = 1'b0;
        partial       = 1'b0;
        dx     = longint'(px) - longint'(cx_sh);
        dy     = longint'(py) - longint'(cy_sh);
        d2     = dx * dx + dy * dy;
        r      = longint'(rad_sh);
        rad_sq = r * r;
        if (r != 0 && d2 <= rad_sq + r)
        begin
            if (d2 <= rad_sq - r)
            begin
                res.pixel_out = fill_sh;
                res.written   = 1'b1;
            end
            else
            begin
                // rim: alpha = (2r+1)*2^(F-1) - ceil(sqrt(d2 * 2^2F))
                scaled = longint'(d2) << (2 * CovFracBits);
                root   = root_floor(scaled);
                if (root * root < scaled)
                    root++;
                k     = (2 * r + 1) << (CovFracBits - 1);
                alpha = k - longint'(root);
                if (alpha >= One)
                begin
                    res.pixel_out = fill_sh;
                    res.written   = 1'b1;
                end
                else if (alpha > 0)
                begin
                    for (int c = 0; c < NumChan; c++)
                    begin
                        fg = longint'(fill_sh[c*ChanW +: ChanW]);
                        bg = longint'(dst[c*ChanW +: ChanW]);
                        res.pixel_out[c*ChanW +: ChanW] =
                            ChanW'((fg * alpha + bg * (One - alpha)) >>> CovFracBits);
                    end
                    res.written = 1'b1;
                    partial     = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                         input logic [CfgDataW-1:0] data);
        return '{ROW_CFG, idx, '0, '0, data, 1'b0, '0, 1'b0};
    endfunction

    function automatic dir_row_t pix_row(input int x, input int y, input int dst);
        return '{ROW_PIXEL, '0, CoordW'(x), CoordW'(y), ColorW'(dst), 1'b0, '0, 1'b0};
    endfunction

    function automatic dir_row_t pix_row_typed(input int x, input int y, input int dst,
                                               input int out, input bit wr);
        return '{ROW_PIXEL, '0, CoordW'(x), CoordW'(y), ColorW'(dst), 1'b1,
                 ColorW'(out), wr};
    endfunction

    // Register write; shadow follows on acceptance
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CENTER_X:   cx_sh   = data[CenterW-1:0];
            REG_CENTER_Y:   cy_sh   = data[CenterW-1:0];
            REG_RADIUS:     rad_sh  = data[RadW-1:0];
            REG_FILL_COLOR: fill_sh = data[ColorW-1:0];
            default:        ;
        endcase
        n_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel request, leave tvalid high, log the expected shade on accept
    task automatic send_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                              input logic [ColorW-1:0] dst, input logic typed,
                              input logic [ColorW-1:0] exp_out, input logic exp_wr);
        shade_t expv;
        bit     partial;
        expv = shade_pixel(x, y, dst, partial);
        if (typed)
            expv = '{exp_out, exp_wr};
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, y, x};
        do @(posedge clk); while (!s_tready);
        shaded_q.push_back(expv);
        n_pixels++;
        if (partial)
            n_partial++;
    endtask

    // Wait until every expected pixel is back, then let the pipeline settle
    task automatic drain_results();
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Random pixel, mostly on or near the rim of the current disc
    task automatic pick_pixel(output logic [CoordW-1:0] x, output logic [CoordW-1:0] y);
        int r, dx, dy, m, mode, xi, yi, sw;
        r    = int'(rad_sh);
        mode = $urandom_range(0, 99);
        if (r == 0 || mode >= 85)
        begin
            x = CoordW'($urandom_range(0, MaxCoord));
            y = CoordW'($urandom_range(0, MaxCoord));
        end
        else
        begin
            dx = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
            dy = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
            if (mode < 45)
            begin
                dx = int'($urandom_range(0, 2 * r)) - r;
                m  = int'(root_floor(longint'(r * r + r - dx * dx)))
                     - int'($urandom_range(0, 2));
                if (m < 0)
                    m = 0;
                dy = $urandom_range(0, 1) ? m : -m;
            end
            if ($urandom_range(0, 1))
            begin
                sw = dx;
                dx = dy;
                dy = sw;
            end
            xi = int'(cx_sh) + dx;
            yi = int'(cy_sh) + dy;
            x = (xi < 0 || xi > MaxCoord) ? CoordW'($urandom_range(0, MaxCoord)) : CoordW'(xi);
            y = (yi < 0 || yi > MaxCoord) ? CoordW'($urandom_range(0, MaxCoord)) : CoordW'(yi);
        end
    endtask

    // Random disc; upper data bits are junk the block must drop
    task automatic pick_disc();
        logic [CfgDataW-1:0] data;
        int                  sel;
        data = CfgDataW'($urandom);
        data[CenterW-1:0] = ($urandom_range(0, 3) == 0) ? CenterW'($urandom)
                                                        : CenterW'($urandom_range(0, MaxCoord));
        write_reg(REG_CENTER_X, data);
        data = CfgDataW'($urandom);
        data[CenterW-1:0] = ($urandom_range(0, 3) == 0) ? CenterW'($urandom)
                                                        : CenterW'($urandom_range(0, MaxCoord));
        write_reg(REG_CENTER_Y, data);
        sel  = $urandom_range(0, 9);
        data = CfgDataW'($urandom);
        if (sel < 4)
            data[RadW-1:0] = RadW'($urandom_range(1, 16));
        else if (sel < 7)
            data[RadW-1:0] = RadW'($urandom_range(17, 400));
        else if (sel < 9)
            data[RadW-1:0] = RadW'($urandom_range(401, 4095));
        else
            data[RadW-1:0] = $urandom_range(0, 1) ? RadW'(4095) : RadW'(0);
        write_reg(REG_RADIUS, data);
        write_reg(REG_FILL_COLOR, CfgDataW'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_reg(SpareRegIdx, CfgDataW'($urandom));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser)
                n_written++;
            if (shaded_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MaxReports)
                    $display("%0t: unexpected pixel out=%06h written=%0b", $time, m_tdata, m_tuser);
            end
            else
            begin
                want = shaded_q.pop_front();
                if (m_tdata !== want.pixel_out)
                begin
                    err_cnt++;
                    if (err_cnt <= MaxReports)
                        $display("%0t: pixel_out expected %06h actual %06h",
                                 $time, want.pixel_out, m_tdata);
                end
                if (m_tuser !== want.written)
                begin
                    err_cnt++;
                    if (err_cnt <= MaxReports)
                        $display("%0t: written expected %0b actual %0b",
                                 $time, want.written, m_tuser);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
            $display("antialiased_disc_pixel_shader verification failed");
            $finish;
        end
    end

    // Output side: stall patterns in segments, plus one long hold-off on request
    initial
    begin
        int mode;
        int seg;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                seg  = $urandom_range(8, 64);
                while (seg > 0 && !hold_req)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= (seg % 4 == 0);
                    endcase
                    seg--;
                    @(posedge clk);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [CoordW-1:0] x, y;
        int                burst_left;
        int                gap;
        bit                steady;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cx_sh     = '0;
        cy_sh     = '0;
        rad_sh    = '0;
        fill_sh   = '0;

        // Reset values: radius zero, nothing drawn
        dir_rows.push_back(pix_row_typed(0, 0, 'h123456, 'h123456, 0));
        dir_rows.push_back(pix_row_typed(4095, 4095, 'hFFFFFF, 'hFFFFFF, 0));
        // Small disc at (100,200), r=10; spare index must be ignored
        dir_rows.push_back(cfg_row(REG_CENTER_X, 24'd100));
        dir_rows.push_back(cfg_row(REG_CENTER_Y, 24'd200));
        dir_rows.push_back(cfg_row(REG_RADIUS, 24'd10));
        dir_rows.push_back(cfg_row(REG_FILL_COLOR, 24'hFF8000));
        dir_rows.push_back(cfg_row(SpareRegIdx, 24'hABCDEF));
        dir_rows.push_back(pix_row_typed(100, 200, 'h0000FF, 'hFF8000, 1));
        dir_rows.push_back(pix_row_typed(105, 200, 'h123456, 'hFF8000, 1));
        dir_rows.push_back(pix_row_typed(111, 200, 'h654321, 'h654321, 0));
        dir_rows.push_back(pix_row_typed(0, 0, 'hA5A5A5, 'hA5A5A5, 0));
        dir_rows.push_back(pix_row(110, 200, 'h00FF00));
        dir_rows.push_back(pix_row(107, 207, 'hFFFFFF));
        dir_rows.push_back(pix_row(100, 210, 'h000000));
        dir_rows.push_back(pix_row(109, 205, 'h808080));
        // Extreme registers: centre (4095,-4096), max radius, white fill
        dir_rows.push_back(cfg_row(REG_CENTER_X, 24'h000FFF));
        dir_rows.push_back(cfg_row(REG_CENTER_Y, 24'h001000));   // -4096
        dir_rows.push_back(cfg_row(REG_RADIUS, 24'h000FFF));
        dir_rows.push_back(cfg_row(REG_FILL_COLOR, 24'hFFFFFF));
        dir_rows.push_back(pix_row_typed(0, 0, 'h111111, 'h111111, 0));
        dir_rows.push_back(pix_row_typed(4095, 0, 'hFFFFFF, 'hFFFFFF, 0));
        // Centre in the far corner, rim crosses the image edge
        dir_rows.push_back(cfg_row(REG_CENTER_Y, 24'h000FFF));
        dir_rows.push_back(pix_row_typed(4095, 4095, 'h000000, 'hFFFFFF, 1));
        dir_rows.push_back(pix_row_typed(0, 0, 'h5A5A5A, 'h5A5A5A, 0));
        dir_rows.push_back(pix_row(0, 4095, 'h000000));
        dir_rows.push_back(pix_row(0, 4094, 'hFFFFFF));
        // Unit disc at origin with black fill
        dir_rows.push_back(cfg_row(REG_CENTER_X, 24'd0));
        dir_rows.push_back(cfg_row(REG_CENTER_Y, 24'd0));
        dir_rows.push_back(cfg_row(REG_RADIUS, 24'd1));
        dir_rows.push_back(cfg_row(REG_FILL_COLOR, 24'h000000));
        dir_rows.push_back(pix_row_typed(0, 0, 'hFFFFFF, 'h000000, 1));
        dir_rows.push_back(pix_row_typed(2, 0, 'hABCDEF, 'hABCDEF, 0));
        dir_rows.push_back(pix_row(1, 0, 'hFFFFFF));
        dir_rows.push_back(pix_row(1, 1, 'h123456));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                s_tvalid <= 1'b0;
                drain_results();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
                send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].val,
                           dir_rows[i].typed, dir_rows[i].exp_out, dir_rows[i].exp_wr);
        end
        s_tvalid <= 1'b0;

        // Random discs, bursts of requests with gaps
        for (int ph = 0; ph < NumRandPhases; ph++)
        begin
            drain_results();
            pick_disc();
            steady     = (ph % 3 == 1) || (ph == HoldPhase);
            burst_left = 0;
            if (ph == HoldPhase)
                hold_req <= 1'b1;
            for (int n = 0; n < ItemsPerPhase; n++)
            begin
                if (!steady && burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 20);
                end
                if (burst_left > 0)
                    burst_left--;
                pick_pixel(x, y);
                send_pixel(x, y, ColorW'($urandom), 1'b0, '0, 1'b0);
            end
            s_tvalid <= 1'b0;
        end

        drain_results();
        $display("Shaded %0d pixels (%0d written, %0d partially covered) over %0d register writes",
                 n_pixels, n_written, n_partial, n_writes);
        if (err_cnt == 0)
            $display("antialiased_disc_pixel_shader verification clean");
        else
            $display("antialiased_disc_pixel_shader verification failed");
        $finish;
    end

endmodule

>>> files.f
design/adcps_pkg.sv
design/adcps_front.sv
design/adcps_fifo.sv
design/adcps_back.sv
design/antialiased_disc_pixel_shader.sv
sim/tb_top.sv
